[hw/rtl/stc_pkg.sv]
// Shared types, constants and helper functions for the serial time to calendar block.
// No dependencies; every module of the block imports this package.
package stc_pkg;

  localparam int TMS_W  = 44;
  localparam int DNUM_W = 18;
  localparam int DREM_W = 27;
  localparam int YIDX_W = 9;
  localparam int OFF_W  = 18;
  localparam int DOY_W  = 9;

  localparam logic [DREM_W-1:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [DREM_W-1:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [DREM_W-1:0] MS_PER_MIN  = 27'd60000;
  localparam logic [DREM_W-1:0] MS_PER_SEC  = 27'd1000;
  localparam logic [11:0]       BASE_YEAR   = 12'd1900;
  localparam logic [3:0]        LAST_MONTH  = 4'd12;

  typedef struct packed {
    logic [TMS_W-1:0] total_ms;
  } stc_in_t;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic        out_of_range;
  } stc_out_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic        out_of_range;
  } stc_date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } stc_tod_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CAL,
    ST_PUSH
  } stc_state_t;

  typedef enum logic [2:0] {
    TOD_IDLE,
    TOD_HOUR,
    TOD_MIN,
    TOD_SEC,
    TOD_DONE
  } stc_tod_ph_t;

  typedef enum logic [2:0] {
    YR_IDLE,
    YR_OFF,
    YR_CMP,
    YR_CHK,
    YR_MON,
    YR_DONE
  } stc_yr_state_t;

  // floor(x / 25) for x up to 602
  function automatic logic [4:0] div25(input logic [9:0] x);
    logic [15:0] p;
    p = {6'd0, x} * 16'd41;
    return p[14:10];
  endfunction

  // days from the epoch to the end of year 1900+k-1 (1900 counted as leap)
  function automatic logic [OFF_W-1:0] year_offset(input logic [YIDX_W-1:0] k);
    logic [11:0]      v;
    logic [9:0]       a4;
    logic [4:0]       a100;
    logic [4:0]       a400;
    logic [OFF_W-1:0] base;
    logic [OFF_W-1:0] lp;
    v    = BASE_YEAR - 12'd1 + {3'd0, k};
    a4   = v[11:2];
    a100 = div25(a4);
    a400 = div25({2'd0, v[11:4]});
    base = {9'd0, k} * 18'd365;
    lp   = ({8'd0, a4} - 18'd474)
         - ({13'd0, a100} - 18'd18)
         + ({13'd0, a400} - 18'd4)
         + {17'd0, (k != '0)};
    return base + lp;
  endfunction

  function automatic logic year_is_leap(input logic [YIDX_W-1:0] k);
    logic [11:0] y;
    logic [4:0]  q;
    logic [4:0]  q4;
    logic [9:0]  r;
    logic [9:0]  r4;
    y  = BASE_YEAR + {3'd0, k};
    q  = div25(y[11:2]);
    r  = y[11:2] - ({5'd0, q} * 10'd25);
    q4 = div25({2'd0, y[11:4]});
    r4 = {2'd0, y[11:4]} - ({5'd0, q4} * 10'd25);
    if (k == '0) begin
      return 1'b1;
    end
    return (y[1:0] == 2'd0) && ((r != 10'd0) || ((y[3:0] == 4'd0) && (r4 == 10'd0)));
  endfunction

  // days before the first day of month m+1
  function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [3:0] m);
    logic [DOY_W-1:0] c;
    case (m)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      4'd12:   c = 9'd365;
      default: c = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

[hw/rtl/stc_chan_if.sv]
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter, normally a struct from stc_pkg.
interface stc_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/serial_time_to_calendar_core.sv]
// Top level of the serial time to calendar converter.
// Instantiates stc_ms_div, stc_year and stc_tod; depends on stc_pkg and stc_chan_if.
//
// Converts a millisecond count since the 1900 serial epoch (day 1 is January 1 1900,
// 1900 counted as a leap year) into year, month, day, hour, minute, second and
// millisecond, one result beat per input beat; day zero or a day past the last table
// year sets out_of_range and zeroes every other field. One item is worked at a time:
// the bit-serial split into day number and time of day, then the bitwise year search,
// a check step and the month scan (the time-of-day split runs alongside), then the
// hand-off of the result. A finished result sits in an output register, so the next
// input beat is taken while it waits to be read; a result not yet read holds back the
// one after it.
module serial_time_to_calendar_core
  import stc_pkg::*;
#(
  parameter int YEAR_TABLE_SIZE = 301
) (
  input  logic        clk,
  input  logic        rst_n,
  stc_chan_if.sink    in_ch,
  stc_chan_if.source  out_ch
);

  stc_state_t        state_r;
  stc_state_t        state_nxt;
  logic              in_fire;
  logic              div_done;
  logic [DNUM_W-1:0] dnum;
  logic [DREM_W-1:0] drem;
  logic              yr_done;
  logic              tod_done;
  stc_date_t         date;
  stc_tod_t          tod;
  logic              yr_seen_r;
  logic              tod_seen_r;
  logic              cal_all;
  logic              out_free;
  logic              load;
  logic              out_valid_r;
  stc_out_t          out_data_r;
  stc_out_t          res;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cal_all  = (yr_seen_r || yr_done) && (tod_seen_r || tod_done);
  assign out_free = !out_valid_r || out_ch.ready;
  assign load     = (state_r == ST_PUSH) && out_free;

  stc_ms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .total_ms (in_ch.data.total_ms),
    .done     (div_done),
    .dnum     (dnum),
    .rem      (drem)
  );

  stc_year #(
    .YEAR_TABLE_SIZE (YEAR_TABLE_SIZE)
  ) u_year (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_done),
    .dnum  (dnum),
    .done  (yr_done),
    .date  (date)
  );

  stc_tod u_tod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_done),
    .rem   (drem),
    .done  (tod_done),
    .tod   (tod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_CAL;
      ST_CAL:  if (cal_all) state_nxt = ST_PUSH;
      ST_PUSH: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = state_r == ST_IDLE;
    out_ch.valid = out_valid_r;
    out_ch.data  = out_data_r;
  end

  always_comb begin
    res              = '0;
    res.out_of_range = date.out_of_range;
    if (!date.out_of_range) begin
      res.month        = date.month;
      res.day_of_month = date.day_of_month;
      res.year         = date.year;
      res.hour         = tod.hour;
      res.minute       = tod.minute;
      res.second       = tod.second;
      res.millisecond  = tod.millisecond;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      yr_seen_r   <= 1'b0;
      tod_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_done) begin
        yr_seen_r  <= 1'b0;
        tod_seen_r <= 1'b0;
      end else begin
        if (yr_done) yr_seen_r <= 1'b1;
        if (tod_done) tod_seen_r <= 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("day split finished outside its phase");

  a_cal_done_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (yr_done || tod_done) |-> state_r == ST_CAL)
    else $error("calendar unit finished outside its phase");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_range) |->
      (out_data_r.year == '0 && out_data_r.month == '0 && out_data_r.hour == '0 &&
       out_data_r.millisecond == '0))
    else $error("out of range beat carries nonzero fields");

  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.out_of_range) |->
      (out_data_r.month >= 4'd1 && out_data_r.month <= 4'd12 &&
       out_data_r.day_of_month >= 5'd1 && out_data_r.hour <= 5'd23 &&
       out_data_r.minute <= 6'd59 && out_data_r.second <= 6'd59 &&
       out_data_r.millisecond <= 10'd999))
    else $error("result beat holds an impossible date or time");
`endif

endmodule

[hw/rtl/stc_ms_div.sv]
// Bit-serial restoring divider: millisecond count by milliseconds per day.
// One quotient bit per cycle. Depends on stc_pkg.
module stc_ms_div
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TMS_W-1:0]  total_ms,
  output logic              done,
  output logic [DNUM_W-1:0] dnum,
  output logic [DREM_W-1:0] rem
);

  localparam int CNT_W = $clog2(TMS_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TMS_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TMS_W-1:0]  num_r;
  logic [DREM_W-1:0] rem_r;
  logic [DREM_W:0]   trial;
  logic              fit;
  logic [DREM_W-1:0] rem_nxt;

  assign trial   = {rem_r, num_r[TMS_W-1]};
  assign fit     = trial >= {1'b0, MS_PER_DAY};
  assign rem_nxt = fit ? DREM_W'(trial - {1'b0, MS_PER_DAY}) : trial[DREM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_LAST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= total_ms;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[TMS_W-2:0], fit};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign dnum = num_r[DNUM_W-1:0];
  assign rem  = rem_r;

endmodule

[hw/rtl/stc_tod.sv]
// Time-of-day split: remainder within the day into hour, minute, second, millisecond.
// Shared restoring subtract, one quotient bit per cycle. Depends on stc_pkg.
module stc_tod
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DREM_W-1:0] rem,
  output logic              done,
  output stc_tod_t          tod
);

  localparam logic [DREM_W-1:0] HOUR_DIV0 = MS_PER_HOUR << 4;
  localparam logic [DREM_W-1:0] MIN_DIV0  = MS_PER_MIN << 5;
  localparam logic [DREM_W-1:0] SEC_DIV0  = MS_PER_SEC << 5;

  stc_tod_ph_t       ph_r;
  stc_tod_ph_t       ph_nxt;
  logic [DREM_W-1:0] acc_r;
  logic [DREM_W-1:0] div_r;
  logic [2:0]        cnt_r;
  logic [5:0]        q_r;
  stc_tod_t          tod_r;
  logic              fit;
  logic              last;
  logic [DREM_W-1:0] acc_nxt;
  logic [5:0]        q_nxt;

  assign fit     = acc_r >= div_r;
  assign last    = cnt_r == 3'd0;
  assign acc_nxt = fit ? acc_r - div_r : acc_r;
  assign q_nxt   = {q_r[4:0], fit};

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      TOD_IDLE: if (start) ph_nxt = TOD_HOUR;
      TOD_HOUR: if (last) ph_nxt = TOD_MIN;
      TOD_MIN:  if (last) ph_nxt = TOD_SEC;
      TOD_SEC:  if (last) ph_nxt = TOD_DONE;
      TOD_DONE: ph_nxt = TOD_IDLE;
      default:  ph_nxt = TOD_IDLE;
    endcase
  end

  always_comb begin
    done = ph_r == TOD_DONE;
    tod  = tod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= TOD_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      TOD_IDLE: begin
        if (start) begin
          acc_r <= rem;
          div_r <= HOUR_DIV0;
          cnt_r <= 3'd4;
          q_r   <= '0;
        end
      end
      TOD_HOUR, TOD_MIN, TOD_SEC: begin
        acc_r <= acc_nxt;
        if (last) begin
          q_r   <= '0;
          cnt_r <= 3'd5;
          case (ph_r)
            TOD_HOUR: begin
              tod_r.hour <= q_nxt[4:0];
              div_r      <= MIN_DIV0;
            end
            TOD_MIN: begin
              tod_r.minute <= q_nxt;
              div_r        <= SEC_DIV0;
            end
            default: begin
              tod_r.second      <= q_nxt;
              tod_r.millisecond <= acc_nxt[9:0];
            end
          endcase
        end else begin
          q_r   <= q_nxt;
          div_r <= div_r >> 1;
          cnt_r <= cnt_r - 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/stc_year.sv]
// Year and month locator: bitwise search of the year-end day table, then month scan.
// Year-end offsets come from a closed form in stc_pkg; depends on stc_pkg.
module stc_year
  import stc_pkg::*;
#(
  parameter int YEAR_TABLE_SIZE = 301
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DNUM_W-1:0] dnum,
  output logic              done,
  output stc_date_t         date
);

  localparam int KW = $clog2(YEAR_TABLE_SIZE);
  localparam logic [KW-1:0] LAST_IDX = KW'(YEAR_TABLE_SIZE - 1);
  localparam logic [KW-1:0] MASK_TOP = KW'(1) << (KW - 1);

  stc_yr_state_t     state_r;
  stc_yr_state_t     state_nxt;
  logic [DNUM_W-1:0] d_r;
  logic [KW-1:0]     j_r;
  logic [KW-1:0]     mask_r;
  logic [OFF_W-1:0]  cand_off_r;
  logic              cand_ok_r;
  logic [OFF_W-1:0]  start_off_r;
  logic              zero_r;
  logic [DOY_W-1:0]  doy_r;
  logic              leap_r;
  logic [3:0]        m_r;
  stc_date_t         date_r;
  logic [KW-1:0]     cand;
  logic              oor_now;
  logic              mon_hit;

  assign cand    = j_r | mask_r;
  assign oor_now = zero_r || (j_r == LAST_IDX);
  assign mon_hit = (m_r == LAST_MONTH) || (doy_r <= cum_days(leap_r, m_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      YR_IDLE: if (start) state_nxt = YR_OFF;
      YR_OFF:  state_nxt = YR_CMP;
      YR_CMP:  state_nxt = mask_r[0] ? YR_CHK : YR_OFF;
      YR_CHK:  state_nxt = oor_now ? YR_DONE : YR_MON;
      YR_MON:  if (mon_hit) state_nxt = YR_DONE;
      YR_DONE: state_nxt = YR_IDLE;
      default: state_nxt = YR_IDLE;
    endcase
  end

  always_comb begin
    done = state_r == YR_DONE;
    date = date_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= YR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      YR_IDLE: begin
        if (start) begin
          d_r         <= dnum;
          j_r         <= '0;
          mask_r      <= MASK_TOP;
          start_off_r <= '0;
          zero_r      <= dnum == '0;
        end
      end
      YR_OFF: begin
        cand_off_r <= year_offset(YIDX_W'(cand));
        cand_ok_r  <= cand <= LAST_IDX;
      end
      YR_CMP: begin
        if (cand_ok_r && (cand_off_r < d_r)) begin
          j_r         <= cand;
          start_off_r <= cand_off_r;
        end
        mask_r <= mask_r >> 1;
      end
      YR_CHK: begin
        doy_r                <= DOY_W'(d_r - start_off_r);
        leap_r               <= year_is_leap(YIDX_W'(j_r));
        m_r                  <= 4'd1;
        date_r.year          <= BASE_YEAR + 12'(j_r);
        date_r.out_of_range  <= oor_now;
        date_r.month         <= '0;
        date_r.day_of_month  <= '0;
      end
      YR_MON: begin
        if (mon_hit) begin
          date_r.month        <= m_r;
          date_r.day_of_month <= 5'(doy_r - cum_days(leap_r, m_r - 4'd1));
        end else begin
          m_r <= m_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
